[design/sdc_pkg.sv]
// Shared types and constants for the stereo downsample crusher.
`default_nettype none
package sdc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int FACTOR_W   = 5;
    localparam int AMOUNT_W   = 17;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_BIAS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_NOISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POST_NOISE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISTORT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POST_CLIP  = 3'd5;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;
    localparam logic [AMOUNT_W-1:0] BIAS_RESET   = 17'd32768;
    localparam logic [AMOUNT_W-1:0] AMOUNT_ONE   = 17'd65536;

    // Random engine
    localparam logic [31:0] LCG_MUL  = 32'd24691;
    localparam logic [31:0] LCG_ADD  = 32'd1103515245;
    localparam logic [31:0] LCG_SEED = 32'd1;

    // Tanh ratio divider: quotient is at most 2^24, so 25 bits
    localparam int RATIO_W   = 25;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd24;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQ,
        OP_SQ_WB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TM,
        OP_TM_WB,
        OP_X1,
        OP_X1_WB,
        OP_X2,
        OP_X2_WB,
        OP_RND,
        OP_NM,
        OP_NM_WB,
        OP_NN,
        OP_NN_WB,
        OP_STORE,
        OP_PUSH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic chan;   // 0 left, 1 right
        logic post;   // 0 pre-hold stage, 1 post-hold stage
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[design/stereo_downsample_crusher.sv]
// Top level of the stereo downsample crusher: config registers, sequencer, datapath.
//
//  channel | ports                                  | contents
//  --------+----------------------------------------+-------------------------------------
//  in      | s_tvalid s_tready s_tdata              | left_sample, right_sample (low first)
//  out     | m_tvalid m_tready m_tdata              | left_out, right_out (low first)
//  config  | cfg_we cfg_index cfg_wdata             | 0 factor .. 5 post clip amount
//
//  The sequencer takes a new item only from idle, after the last one has reached the
//  output register, so items never follow back to back. One channel through one stage
//  is a pass on the single shared multiplier, with the tanh ratio divider in it; a hold
//  frame runs two passes and a processing frame four.
//  Reset (aresetn low, synchronous) clears the phase, held pair and random state.
//  A waiting result sits in the output register while the next item is taken;
//  the sequencer stalls only if that register is still full when it is done.
`default_nettype none
module stereo_downsample_crusher #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int MAX_DOWNSAMPLE = 16,
    localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [TDATA_W-1:0]                s_tdata,   // left_sample, right_sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [TDATA_W-1:0]                     m_tdata,   // left_out, right_out
    input  wire logic                              cfg_we,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sdc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sdc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic [FACTOR_W-1:0] factor_reg;
    logic [AMOUNT_W-1:0] bias_reg, pre_noise_reg, post_noise_reg, distort_reg, post_clip_reg;

    cmd_t                 cmd;
    sts_t                 sts;
    logic signed [SW-1:0] out_left, out_right;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg     <= FACTOR_RESET;
            bias_reg       <= BIAS_RESET;
            pre_noise_reg  <= '0;
            post_noise_reg <= '0;
            distort_reg    <= '0;
            post_clip_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FACTOR:     factor_reg     <= cfg_wdata[FACTOR_W-1:0];
                REG_NOISE_BIAS: bias_reg       <= cfg_wdata;
                REG_PRE_NOISE:  pre_noise_reg  <= cfg_wdata;
                REG_POST_NOISE: post_noise_reg <= cfg_wdata;
                REG_DISTORT:    distort_reg    <= cfg_wdata;
                REG_POST_CLIP:  post_clip_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: decides processing versus hold frames and steps each stage
    sdc_ctrl #(
        .MAX_DOWNSAMPLE (MAX_DOWNSAMPLE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .factor   (factor_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: soft clip, noise, held pair and output register
    sdc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .in_left           ($signed(s_tdata[SW-1:0])),
        .in_right          ($signed(s_tdata[2*SW-1:SW])),
        .noise_bias        (bias_reg),
        .pre_noise_amount  (pre_noise_reg),
        .post_noise_amount (post_noise_reg),
        .distort_amount    (distort_reg),
        .post_clip_amount  (post_clip_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_left          (out_left),
        .out_right         (out_right)
    );

    // Pack the pair, zero padding above
    assign m_tdata = TDATA_W'({out_right, out_left});

    // Nothing is accepted back to back: the sequencer leaves idle on acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while the sequencer was busy");

    // A new result only appears as the sequencer returns to idle
    a_result_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (s_tready && $past(!s_tready)))
        else $error("result raised outside the end of an item");

    // Reset empties the output register and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("reset did not clear the handshake state");

endmodule
`default_nettype wire

[design/sdc_ctrl.sv]
// Sequencer for the crusher: frame phase, stage order and divider count.
`default_nettype none
module sdc_ctrl #(
    parameter int MAX_DOWNSAMPLE = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [sdc_pkg::FACTOR_W-1:0] factor,
    input  wire sdc_pkg::sts_t            sts,
    output sdc_pkg::cmd_t                 cmd
);
    import sdc_pkg::*;

    localparam int PH_W  = (MAX_DOWNSAMPLE > 2) ? $clog2(MAX_DOWNSAMPLE) : 1;
    localparam int CMP_W = 10;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DOWNSAMPLE);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_CSQ, S_CSQ_WB, S_DIV_INIT, S_DIV_STEP, S_TM, S_TM_WB,
        S_X1, S_X1_WB, S_X2, S_X2_WB, S_RND, S_NSQ, S_NSQ_WB, S_NM, S_NM_WB,
        S_NN, S_NN_WB, S_STORE, S_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic                 chan_reg, chan_next;
    logic                 post_reg, post_next;
    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 ready_reg;
    cmd_t                 cmd_reg, cmd_next;

    logic [CMP_W-1:0] fac_raw, fac_eff, ph_inc;

    always_comb begin
        fac_raw = CMP_W'(factor);
        if (fac_raw == '0) begin
            fac_eff = CMP_W'(1);
        end else if (fac_raw > MAX_C) begin
            fac_eff = MAX_C;
        end else begin
            fac_eff = fac_raw;
        end
        ph_inc = CMP_W'(phase_reg) + CMP_W'(1);
    end

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        post_next  = post_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    // skip the pre-hold stage on a hold frame
                    post_next  = (phase_reg != '0);
                    chan_next  = 1'b0;
                    phase_next = (ph_inc >= fac_eff) ? '0 : ph_inc[PH_W-1:0];
                    state_next = S_LOAD;
                end
            end
            S_LOAD:     state_next = S_CSQ;
            S_CSQ:      state_next = S_CSQ_WB;
            S_CSQ_WB:   state_next = S_DIV_INIT;
            S_DIV_INIT: begin
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_TM;
                end
            end
            S_TM:       state_next = S_TM_WB;
            S_TM_WB:    state_next = S_X1;
            S_X1:       state_next = S_X1_WB;
            S_X1_WB:    state_next = S_X2;
            S_X2:       state_next = S_X2_WB;
            S_X2_WB:    state_next = S_RND;
            S_RND:      state_next = S_NSQ;
            S_NSQ:      state_next = S_NSQ_WB;
            S_NSQ_WB:   state_next = S_NM;
            S_NM:       state_next = S_NM_WB;
            S_NM_WB:    state_next = S_NN;
            S_NN:       state_next = S_NN_WB;
            S_NN_WB:    state_next = S_STORE;
            S_STORE: begin
                if (!chan_reg) begin
                    chan_next  = 1'b1;
                    state_next = S_LOAD;
                end else if (!post_reg) begin
                    chan_next  = 1'b0;
                    post_next  = 1'b1;
                    state_next = S_LOAD;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next.chan = chan_next;
        cmd_next.post = post_next;
        case (state_next)
            S_IDLE:     cmd_next.op = OP_IDLE;
            S_LOAD:     cmd_next.op = OP_LOAD;
            S_CSQ:      cmd_next.op = OP_SQ;
            S_CSQ_WB:   cmd_next.op = OP_SQ_WB;
            S_DIV_INIT: cmd_next.op = OP_DIV_INIT;
            S_DIV_STEP: cmd_next.op = OP_DIV_STEP;
            S_TM:       cmd_next.op = OP_TM;
            S_TM_WB:    cmd_next.op = OP_TM_WB;
            S_X1:       cmd_next.op = OP_X1;
            S_X1_WB:    cmd_next.op = OP_X1_WB;
            S_X2:       cmd_next.op = OP_X2;
            S_X2_WB:    cmd_next.op = OP_X2_WB;
            S_RND:      cmd_next.op = OP_RND;
            S_NSQ:      cmd_next.op = OP_SQ;
            S_NSQ_WB:   cmd_next.op = OP_SQ_WB;
            S_NM:       cmd_next.op = OP_NM;
            S_NM_WB:    cmd_next.op = OP_NM_WB;
            S_NN:       cmd_next.op = OP_NN;
            S_NN_WB:    cmd_next.op = OP_NN_WB;
            S_STORE:    cmd_next.op = OP_STORE;
            S_PUSH:     cmd_next.op = OP_PUSH;
            default:    cmd_next.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            chan_reg    <= 1'b0;
            post_reg    <= 1'b0;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            ready_reg   <= 1'b1;
            cmd_reg.op  <= OP_IDLE;
            cmd_reg.chan <= 1'b0;
            cmd_reg.post <= 1'b0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            post_reg  <= post_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ready_reg <= (state_next == S_IDLE);
            cmd_reg   <= cmd_next;
        end
    end

    assign s_tready = ready_reg;
    assign cmd      = cmd_reg;

endmodule
`default_nettype wire

[design/sdc_dp.sv]
// Datapath for the crusher: shared multiplier, ratio divider, random engine.
`default_nettype none
module sdc_dp #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sdc_pkg::cmd_t                   cmd,
    output sdc_pkg::sts_t                        sts,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_left,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  in_right,
    input  wire logic [sdc_pkg::AMOUNT_W-1:0]    noise_bias,
    input  wire logic [sdc_pkg::AMOUNT_W-1:0]    pre_noise_amount,
    input  wire logic [sdc_pkg::AMOUNT_W-1:0]    post_noise_amount,
    input  wire logic [sdc_pkg::AMOUNT_W-1:0]    distort_amount,
    input  wire logic [sdc_pkg::AMOUNT_W-1:0]    post_clip_amount,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]       out_left,
    output logic signed [SAMPLE_WIDTH-1:0]       out_right
);
    import sdc_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int F    = SW - 3;
    localparam int OA_W = SW + 3;
    localparam int OB_W = (SW + 2 > 27) ? SW + 2 : 27;
    localparam int PW   = OA_W + OB_W;
    localparam int EW   = PW + 1;
    localparam int DW   = F + 7;
    localparam int SQ_W = SW + 2;
    localparam logic [SW-1:0] ONE_Q   = SW'(1) << F;
    localparam logic [SW-1:0] THREE_Q = SW'(3) << F;
    localparam logic [DW-1:0] K27     = DW'(27) << F;

    function automatic logic signed [EW-1:0] rshift(input logic signed [EW-1:0] v,
                                                    input int sh);
        logic [EW-1:0] mag;
        mag = v[EW-1] ? EW'(-v) : EW'(v);
        mag = (mag + (EW'(1) << (sh - 1))) >> sh;
        return v[EW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [SW-1:0] sat(input logic signed [EW-1:0] v);
        if (v[EW-1:SW-1] == '0 || v[EW-1:SW-1] == '1) begin
            return v[SW-1:0];
        end
        return v[EW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    endfunction

    function automatic logic [AMOUNT_W-1:0] clamp1(input logic [AMOUNT_W-1:0] v);
        return (v > AMOUNT_ONE) ? AMOUNT_ONE : v;
    endfunction

    logic signed [SW-1:0]   in_l_reg, in_r_reg;
    logic signed [SW-1:0]   held_l_reg, held_r_reg;
    logic signed [SW-1:0]   res_l_reg, res_r_reg;
    logic signed [SW-1:0]   x_reg, t_reg;
    logic signed [SW-1:0]   oleft_reg, oright_reg;
    logic                   ovalid_reg;
    logic [SQ_W-1:0]        s_reg, m_reg;
    logic                   big_reg;
    logic [DW-1:0]          rem_reg, den_reg;
    logic                   lsb_reg;
    logic [RATIO_W-1:0]     q_reg;
    logic signed [PW-1:0]   prod_reg, acc_reg;
    logic [31:0]            lcg_reg;
    logic signed [25:0]     n_reg;

    logic [SW-1:0]          ax;
    logic [AMOUNT_W-1:0]    sc_amt, nz_amt, bias_c;
    logic signed [OA_W-1:0] mul_a;
    logic signed [OB_W-1:0] mul_b;
    logic [2*SW-1:0]        sq_sum;
    logic [DW-1:0]          num, den;
    logic [DW:0]            dtrial;
    logic                   dge;
    logic [SW+25:0]         tm_sum;
    logic [SW-1:0]          tmag;
    logic signed [SW:0]     tb;
    logic [31:0]            draw;
    logic [24:0]            u;
    logic [SW+18:0]         nm_sum;
    logic                   out_free;

    always_comb begin
        ax     = x_reg[SW-1] ? SW'(-x_reg) : SW'(x_reg);
        sc_amt = clamp1(cmd.post ? post_clip_amount : distort_amount);
        nz_amt = clamp1(cmd.post ? post_noise_amount : pre_noise_amount);
        bias_c = clamp1(noise_bias);
        tb     = cmd.post ? (SW+1)'(t_reg) : $signed({t_reg, 1'b0});

        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ: begin
                mul_a = $signed(OA_W'(ax));
                mul_b = $signed(OB_W'(ax));
            end
            OP_TM: begin
                mul_a = $signed(OA_W'(ax));
                mul_b = $signed(OB_W'(q_reg));
            end
            OP_X1: begin
                mul_a = OA_W'(x_reg);
                mul_b = $signed(OB_W'(AMOUNT_ONE - sc_amt));
            end
            OP_X2: begin
                mul_a = OA_W'(tb);
                mul_b = $signed(OB_W'(sc_amt));
            end
            OP_NM: begin
                mul_a = $signed(OA_W'(s_reg));
                mul_b = $signed(OB_W'(nz_amt));
            end
            OP_NN: begin
                mul_a = $signed(OA_W'(m_reg));
                mul_b = OB_W'(n_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        sq_sum = prod_reg[2*SW-1:0] + ((2*SW)'(1) << (F - 1));
        num    = K27 + DW'(s_reg);
        den    = K27 + (DW'(s_reg) << 3) + DW'(s_reg);
        dtrial = {rem_reg, lsb_reg};
        dge    = dtrial >= {1'b0, den_reg};
        tm_sum = {1'b0, prod_reg[SW+24:0]} + (SW+26)'(1 << 23);
        tmag   = big_reg ? ONE_Q : tm_sum[24 +: SW];
        draw   = lcg_reg * LCG_MUL + LCG_ADD;
        // draw * 2^24 / (2^32 - 1) floors to draw >> 8, but for all ones
        u      = (draw == '1) ? 25'(1 << 24) : 25'(draw >> 8);
        nm_sum = prod_reg[SW+18:0] + (SW+19)'(32768);
        out_free = !ovalid_reg || out_ready;
    end

    // control-side state: random engine, held pair, output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg    <= LCG_SEED;
            held_l_reg <= '0;
            held_r_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_RND) begin
                lcg_reg <= draw;
            end
            if (cmd.op == OP_STORE && !cmd.post) begin
                if (cmd.chan) begin
                    held_r_reg <= x_reg;
                end else begin
                    held_l_reg <= x_reg;
                end
            end
            if (cmd.op == OP_PUSH && out_free) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_IDLE: begin
                in_l_reg <= in_left;
                in_r_reg <= in_right;
            end
            OP_LOAD: begin
                if (cmd.post) begin
                    x_reg <= cmd.chan ? held_r_reg : held_l_reg;
                end else begin
                    x_reg <= cmd.chan ? in_r_reg : in_l_reg;
                end
            end
            OP_SQ_WB: begin
                s_reg   <= sq_sum[F +: SQ_W];
                big_reg <= ax > THREE_Q;
            end
            OP_DIV_INIT: begin
                rem_reg <= num >> 1;
                lsb_reg <= num[0];
                den_reg <= den;
                q_reg   <= '0;
            end
            OP_DIV_STEP: begin
                lsb_reg <= 1'b0;
                rem_reg <= dge ? DW'(dtrial - {1'b0, den_reg}) : dtrial[DW-1:0];
                q_reg   <= {q_reg[RATIO_W-2:0], dge};
            end
            OP_TM_WB: t_reg <= x_reg[SW-1] ? -$signed(tmag) : $signed(tmag);
            OP_X1_WB: acc_reg <= prod_reg;
            OP_X2_WB: x_reg <= sat(rshift(EW'(acc_reg) + EW'(prod_reg), 16));
            OP_RND:   n_reg <= $signed({1'b0, u}) - $signed({1'b0, bias_c, 8'b0});
            OP_NM_WB: m_reg <= nm_sum[16 +: SQ_W];
            OP_NN_WB: x_reg <= sat(EW'(x_reg) + rshift(EW'(prod_reg), 24));
            OP_STORE: begin
                if (cmd.post) begin
                    if (cmd.chan) begin
                        res_r_reg <= x_reg;
                    end else begin
                        res_l_reg <= x_reg;
                    end
                end
            end
            OP_PUSH: begin
                if (out_free) begin
                    oleft_reg  <= res_l_reg;
                    oright_reg <= res_r_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign sts.out_free = out_free;
    assign out_valid    = ovalid_reg;
    assign out_left     = oleft_reg;
    assign out_right    = oright_reg;

endmodule
`default_nettype wire
